[rtl/assert_macros.svh]
// Assertion macros shared by the list unit modules.
// Each use stands on a line of its own and needs no trailing semicolon.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("assertion failed");
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, rst_n, expr)
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[rtl/oal_pkg.sv]
package oal_pkg;

	// List geometry
	localparam int CAPACITY = 128;
	localparam int WORD_BITS = 32;
	localparam int ADDR_BITS = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_BITS = $clog2(CAPACITY + 1);

	// Interface field widths
	localparam int OP_BITS = 3;
	localparam int POS_BITS = 7;
	localparam int VALUE_BITS = 32;
	localparam int READ_BITS = 32;
	localparam int COUNT_OUT_BITS = 8;
	localparam int STATUS_BITS = 2;
	localparam int IN_TDATA_BITS = 48;
	localparam int OUT_TDATA_BITS = 48;

	// Compare width that holds both a position and a count
	localparam int CMP_BITS = (CNT_BITS > POS_BITS) ? CNT_BITS : POS_BITS + 1;
	localparam logic [CNT_BITS-1:0] CAP_COUNT = CNT_BITS'(CAPACITY);

	typedef enum logic [OP_BITS-1:0] {
		OP_GET    = 3'd0,
		OP_SET    = 3'd1,
		OP_INSERT = 3'd2,
		OP_DELETE = 3'd3,
		OP_SEARCH = 3'd4
	} op_t;

	typedef enum logic [STATUS_BITS-1:0] {
		ST_OK        = 2'd0,
		ST_BAD_INDEX = 2'd1,
		ST_FULL      = 2'd2,
		ST_EMPTY     = 2'd3
	} status_t;

	// Read address source
	typedef enum logic [1:0] {
		RA_POS = 2'd0,
		RA_K   = 2'd1,
		RA_KM1 = 2'd2,
		RA_KP1 = 2'd3
	} rd_sel_t;

	// Loop index update
	typedef enum logic [2:0] {
		K_HOLD       = 3'd0,
		K_LOAD_COUNT = 3'd1,
		K_LOAD_POS   = 3'd2,
		K_LOAD_ZERO  = 3'd3,
		K_INC        = 3'd4,
		K_DEC        = 3'd5
	} k_op_t;

	typedef struct packed {
		logic    capture;
		k_op_t   k_op;
		logic    rd_en;
		rd_sel_t rd_sel;
		logic    wr_en;
		logic    wr_at_k;
		logic    wr_from_ram;
		logic    cnt_inc;
		logic    cnt_dec;
		logic    set_status;
		status_t status;
		logic    take_read;
		logic    set_found;
		logic    load_result;
	} cmd_t;

	typedef struct packed {
		op_t  op;
		logic pos_lt_cnt;
		logic pos_le_cnt;
		logic full;
		logic empty;
		logic k_gt_pos;
		logic kp1_lt_cnt;
		logic k_lt_cnt;
		logic match;
	} sts_t;

endpackage

[rtl/oal_ram.sv]
module oal_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port, registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[rtl/oal_datapath.sv]
`include "assert_macros.svh"

module oal_datapath (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic [oal_pkg::OP_BITS-1:0]          in_op,
	input  logic [oal_pkg::POS_BITS-1:0]         in_position,
	input  logic [oal_pkg::VALUE_BITS-1:0]       in_value,
	input  oal_pkg::cmd_t                        cmd,
	output oal_pkg::sts_t                        sts,
	output logic [oal_pkg::READ_BITS-1:0]        read_value,
	output logic                                 found,
	output logic [oal_pkg::COUNT_OUT_BITS-1:0]   count_now,
	output logic [oal_pkg::STATUS_BITS-1:0]      status
);

	oal_pkg::op_t                          op_q;
	logic [oal_pkg::POS_BITS-1:0]          pos_q;
	logic [oal_pkg::WORD_BITS-1:0]         val_q;
	logic [oal_pkg::CNT_BITS-1:0]          k_q;
	logic [oal_pkg::CNT_BITS-1:0]          count_q;
	logic [oal_pkg::READ_BITS-1:0]         read_w_q;
	logic                                  found_w_q;
	oal_pkg::status_t                      status_w_q;
	logic [oal_pkg::READ_BITS-1:0]         read_value_q;
	logic                                  found_q;
	logic [oal_pkg::COUNT_OUT_BITS-1:0]    count_now_q;
	logic [oal_pkg::STATUS_BITS-1:0]       status_q;

	logic [oal_pkg::CNT_BITS-1:0]          kp1;
	logic [oal_pkg::CNT_BITS-1:0]          km1;
	logic [oal_pkg::CMP_BITS-1:0]          pos_x;
	logic [oal_pkg::CMP_BITS-1:0]          cnt_x;
	logic [oal_pkg::CMP_BITS-1:0]          wr_idx_x;
	logic [oal_pkg::ADDR_BITS-1:0]         pos_addr;
	logic [oal_pkg::ADDR_BITS-1:0]         rd_addr;
	logic [oal_pkg::ADDR_BITS-1:0]         wr_addr;
	logic [oal_pkg::WORD_BITS-1:0]         wr_data;
	logic [oal_pkg::WORD_BITS-1:0]         ram_rdata;

	// Neighbour indices and widened operands for compares
	assign kp1      = k_q + oal_pkg::CNT_BITS'(1);
	assign km1      = k_q - oal_pkg::CNT_BITS'(1);
	assign pos_x    = oal_pkg::CMP_BITS'(pos_q);
	assign cnt_x    = oal_pkg::CMP_BITS'(count_q);
	assign pos_addr = oal_pkg::ADDR_BITS'(pos_q);

	// Select read address
	always_comb begin
		case (cmd.rd_sel)
			oal_pkg::RA_POS: rd_addr = pos_addr;
			oal_pkg::RA_K:   rd_addr = k_q[oal_pkg::ADDR_BITS-1:0];
			oal_pkg::RA_KM1: rd_addr = km1[oal_pkg::ADDR_BITS-1:0];
			oal_pkg::RA_KP1: rd_addr = kp1[oal_pkg::ADDR_BITS-1:0];
			default:         rd_addr = pos_addr;
		endcase
	end

	// Select write address and data
	assign wr_addr  = cmd.wr_at_k ? k_q[oal_pkg::ADDR_BITS-1:0] : pos_addr;
	assign wr_data  = cmd.wr_from_ram ? ram_rdata : val_q;
	assign wr_idx_x = cmd.wr_at_k ? oal_pkg::CMP_BITS'(k_q) : pos_x;

	oal_ram #(
		.WIDTH (oal_pkg::WORD_BITS),
		.DEPTH (oal_pkg::CAPACITY)
	) u_store (
		.clk   (clk),
		.we    (cmd.wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.re    (cmd.rd_en),
		.raddr (rd_addr),
		.rdata (ram_rdata)
	);

	// Status towards the controller
	always_comb begin
		sts.op         = op_q;
		sts.pos_lt_cnt = pos_x < cnt_x;
		sts.pos_le_cnt = pos_x <= cnt_x;
		sts.full       = count_q == oal_pkg::CAP_COUNT;
		sts.empty      = count_q == '0;
		sts.k_gt_pos   = oal_pkg::CMP_BITS'(k_q) > pos_x;
		sts.kp1_lt_cnt = kp1 < count_q;
		sts.k_lt_cnt   = k_q < count_q;
		sts.match      = ram_rdata == val_q;
	end

	// Hold the item fields for the length of the operation
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q      <= oal_pkg::OP_GET;
			found_w_q <= 1'b0;
		end else if (cmd.capture) begin
			op_q      <= oal_pkg::op_t'(in_op);
			found_w_q <= 1'b0;
		end else if (cmd.set_found) begin
			found_w_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			pos_q <= in_position;
			val_q <= oal_pkg::WORD_BITS'(in_value);
		end
	end

	// Advance the loop index
	always_ff @(posedge clk) begin
		case (cmd.k_op)
			oal_pkg::K_HOLD:       k_q <= k_q;
			oal_pkg::K_LOAD_COUNT: k_q <= count_q;
			oal_pkg::K_LOAD_POS:   k_q <= oal_pkg::CNT_BITS'(pos_q);
			oal_pkg::K_LOAD_ZERO:  k_q <= '0;
			oal_pkg::K_INC:        k_q <= kp1;
			oal_pkg::K_DEC:        k_q <= km1;
			default:               k_q <= k_q;
		endcase
	end

	// Element count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.cnt_inc) begin
			count_q <= count_q + oal_pkg::CNT_BITS'(1);
		end else if (cmd.cnt_dec) begin
			count_q <= count_q - oal_pkg::CNT_BITS'(1);
		end
	end

	// Working result of the current item
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			read_w_q   <= '0;
			status_w_q <= oal_pkg::ST_OK;
		end else begin
			if (cmd.take_read) begin
				read_w_q <= oal_pkg::READ_BITS'(ram_rdata);
			end
			if (cmd.set_status) begin
				status_w_q <= cmd.status;
			end
		end
	end

	// Output register, loaded once the previous result has gone
	always_ff @(posedge clk) begin
		if (cmd.load_result) begin
			read_value_q <= read_w_q;
			found_q      <= found_w_q;
			count_now_q  <= oal_pkg::COUNT_OUT_BITS'(count_q);
			status_q     <= status_w_q;
		end
	end

	assign read_value = read_value_q;
	assign found      = found_q;
	assign count_now  = count_now_q;
	assign status     = status_q;

	`ASSERT_ALWAYS(a_count_cap, clk, arst_n, count_q <= oal_pkg::CAP_COUNT)
	`ASSERT_IMPLIES(a_wr_in_list, clk, arst_n, cmd.wr_en, wr_idx_x <= cnt_x)
	`ASSERT_IMPLIES(a_found_search, clk, arst_n, found_w_q, op_q == oal_pkg::OP_SEARCH)

endmodule

[rtl/oal_ctrl.sv]
`include "assert_macros.svh"

module oal_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	output logic          m_tvalid,
	input  logic          m_tready,
	input  oal_pkg::sts_t sts,
	output oal_pkg::cmd_t cmd
);

	typedef enum logic [9:0] {
		S_IDLE     = 10'b00_0000_0001,
		S_DECODE   = 10'b00_0000_0010,
		S_GET_WAIT = 10'b00_0000_0100,
		S_INS_CHK  = 10'b00_0000_1000,
		S_INS_WR   = 10'b00_0001_0000,
		S_DEL_CHK  = 10'b00_0010_0000,
		S_DEL_WR   = 10'b00_0100_0000,
		S_SRCH_CHK = 10'b00_1000_0000,
		S_SRCH_CMP = 10'b01_0000_0000,
		S_DONE     = 10'b10_0000_0000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   m_tvalid_q;

	// Sequence each operation
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.capture = 1'b1;
					state_d     = S_DECODE;
				end
			end
			S_DECODE: begin
				state_d = S_DONE;
				case (sts.op)
					oal_pkg::OP_GET: begin
						if (sts.pos_lt_cnt) begin
							cmd.rd_en  = 1'b1;
							cmd.rd_sel = oal_pkg::RA_POS;
							state_d    = S_GET_WAIT;
						end else begin
							cmd.set_status = 1'b1;
							cmd.status     = oal_pkg::ST_BAD_INDEX;
						end
					end
					oal_pkg::OP_SET: begin
						if (sts.pos_lt_cnt) begin
							cmd.wr_en = 1'b1;
						end else begin
							cmd.set_status = 1'b1;
							cmd.status     = oal_pkg::ST_BAD_INDEX;
						end
					end
					oal_pkg::OP_INSERT: begin
						if (sts.full) begin
							cmd.set_status = 1'b1;
							cmd.status     = oal_pkg::ST_FULL;
						end else if (!sts.pos_le_cnt) begin
							cmd.set_status = 1'b1;
							cmd.status     = oal_pkg::ST_BAD_INDEX;
						end else begin
							cmd.k_op = oal_pkg::K_LOAD_COUNT;
							state_d  = S_INS_CHK;
						end
					end
					oal_pkg::OP_DELETE: begin
						if (sts.empty) begin
							cmd.set_status = 1'b1;
							cmd.status     = oal_pkg::ST_EMPTY;
						end else if (!sts.pos_lt_cnt) begin
							cmd.set_status = 1'b1;
							cmd.status     = oal_pkg::ST_BAD_INDEX;
						end else begin
							cmd.k_op = oal_pkg::K_LOAD_POS;
							state_d  = S_DEL_CHK;
						end
					end
					oal_pkg::OP_SEARCH: begin
						cmd.k_op = oal_pkg::K_LOAD_ZERO;
						state_d  = S_SRCH_CHK;
					end
					default: begin
						state_d = S_DONE;
					end
				endcase
			end
			S_GET_WAIT: begin
				cmd.take_read = 1'b1;
				state_d       = S_DONE;
			end
			// Shift up from the tail, then drop the new value in
			S_INS_CHK: begin
				if (sts.k_gt_pos) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = oal_pkg::RA_KM1;
					state_d    = S_INS_WR;
				end else begin
					cmd.wr_en   = 1'b1;
					cmd.cnt_inc = 1'b1;
					state_d     = S_DONE;
				end
			end
			S_INS_WR: begin
				cmd.wr_en       = 1'b1;
				cmd.wr_at_k     = 1'b1;
				cmd.wr_from_ram = 1'b1;
				cmd.k_op        = oal_pkg::K_DEC;
				state_d         = S_INS_CHK;
			end
			// Shift down over the removed element
			S_DEL_CHK: begin
				if (sts.kp1_lt_cnt) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = oal_pkg::RA_KP1;
					state_d    = S_DEL_WR;
				end else begin
					cmd.cnt_dec = 1'b1;
					state_d     = S_DONE;
				end
			end
			S_DEL_WR: begin
				cmd.wr_en       = 1'b1;
				cmd.wr_at_k     = 1'b1;
				cmd.wr_from_ram = 1'b1;
				cmd.k_op        = oal_pkg::K_INC;
				state_d         = S_DEL_CHK;
			end
			// Scan from the head, stop on the first match
			S_SRCH_CHK: begin
				if (sts.k_lt_cnt) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = oal_pkg::RA_K;
					state_d    = S_SRCH_CMP;
				end else begin
					state_d = S_DONE;
				end
			end
			S_SRCH_CMP: begin
				if (sts.match) begin
					cmd.set_found = 1'b1;
					state_d       = S_DONE;
				end else begin
					cmd.k_op = oal_pkg::K_INC;
					state_d  = S_SRCH_CHK;
				end
			end
			S_DONE: begin
				if (!m_tvalid_q || m_tready) begin
					cmd.load_result = 1'b1;
					state_d         = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Result valid: set on load, drop once the transfer completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.load_result) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	assign s_tready = state_q == S_IDLE;
	assign m_tvalid = m_tvalid_q;

	`ASSERT_IMPLIES(a_no_overwrite, clk, arst_n, cmd.load_result, !m_tvalid_q || m_tready)
	`ASSERT_NEXT(a_load_shows, clk, arst_n, cmd.load_result, m_tvalid_q)

endmodule

[rtl/ordered_array_list_unit.sv]
// Channel  | Dir | Signals                     | Contents
// s_axis   | in  | s_tvalid s_tready s_tdata   | op, position, value
// m_axis   | out | m_tvalid m_tready m_tdata   | read_value, found, count_now, status
//
// Time per item, accept to next accept with the output free, grows with count - position
// for insert and delete and with the elements scanned for search, and a match ends the
// scan early; any rejected item or unused op code goes from decode straight to done.
// The element store has one write and one registered read port; every shift or
// compare step is a read state followed by a write or compare state.
// Reset clears the element count and the control state; the store is not cleared.
// A new item is accepted while the previous result still waits on m_tready; the
// unit holds in its final step until the output register is free.
module ordered_array_list_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// [2:0] op, [9:3] position, [41:10] value, [47:42] zero
	input  logic [oal_pkg::IN_TDATA_BITS-1:0]    s_tdata,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// [31:0] read_value, [32] found, [40:33] count_now, [42:41] status, [47:43] zero
	output logic [oal_pkg::OUT_TDATA_BITS-1:0]   m_tdata
);

	oal_pkg::cmd_t                           cmd;
	oal_pkg::sts_t                           sts;
	logic [oal_pkg::READ_BITS-1:0]           read_value;
	logic                                    found;
	logic [oal_pkg::COUNT_OUT_BITS-1:0]      count_now;
	logic [oal_pkg::STATUS_BITS-1:0]         status;

	oal_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	oal_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_op       (s_tdata[2:0]),
		.in_position (s_tdata[9:3]),
		.in_value    (s_tdata[41:10]),
		.cmd         (cmd),
		.sts         (sts),
		.read_value  (read_value),
		.found       (found),
		.count_now   (count_now),
		.status      (status)
	);

	// Pack the result transfer
	assign m_tdata = {5'b0, status, count_now, found, read_value};

endmodule

[dv/testbench.sv]
module testbench;

	// Op codes outside the defined set; the unit must treat them as no-ops
	localparam logic [oal_pkg::OP_BITS-1:0] OP_SPARE_LO = 3'd5;
	localparam logic [oal_pkg::OP_BITS-1:0] OP_SPARE_HI = 3'd7;
	localparam int RANDOM_ITEMS = 500;
	localparam int DRAIN_CYCLES = 300;
	localparam int HOLD_OFF_CYCLES = 400;

	typedef struct packed {
		logic [oal_pkg::READ_BITS-1:0]      read_value;
		logic                               found;
		logic [oal_pkg::COUNT_OUT_BITS-1:0] count_now;
		oal_pkg::status_t                   status;
	} list_result_t;

	typedef struct packed {
		logic [oal_pkg::OP_BITS-1:0]    op;
		logic [oal_pkg::POS_BITS-1:0]   pos;
		logic [oal_pkg::VALUE_BITS-1:0] value;
		logic                           typed;
		list_result_t                   want;
	} stim_row_t;

	typedef enum logic [1:0] {
		RX_OPEN,
		RX_COIN,
		RX_SPARSE
	} rx_mode_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [oal_pkg::IN_TDATA_BITS-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [oal_pkg::OUT_TDATA_BITS-1:0] m_tdata;

	// Predicted list contents and length
	logic [oal_pkg::WORD_BITS-1:0] list_words [oal_pkg::CAPACITY];
	int list_len = 0;
	list_result_t pending_results [$];

	int mismatches = 0;
	int results_seen = 0;
	int burst_left = 0;
	bit fill_mode = 1'b1;

	bit held_off = 1'b0;
	int hold_cycles = 0;
	int rx_phase = 0;
	rx_mode_t rx_mode = RX_OPEN;

	// Opening rows: empty list, boundaries, every op and the bad-index and empty error codes
	stim_row_t opening_rows [24] = '{
		'{oal_pkg::OP_GET, 7'd0, 32'd0, 1'b1, '{32'd0, 1'b0, 8'd0, oal_pkg::ST_BAD_INDEX}},
		'{oal_pkg::OP_SET, 7'd0, 32'd0, 1'b1, '{32'd0, 1'b0, 8'd0, oal_pkg::ST_BAD_INDEX}},
		'{oal_pkg::OP_DELETE, 7'd0, 32'd0, 1'b1, '{32'd0, 1'b0, 8'd0, oal_pkg::ST_EMPTY}},
		'{oal_pkg::OP_SEARCH, 7'd0, 32'd0, 1'b1, '{32'd0, 1'b0, 8'd0, oal_pkg::ST_OK}},
		'{oal_pkg::OP_INSERT, 7'd1, 32'd5, 1'b1, '{32'd0, 1'b0, 8'd0, oal_pkg::ST_BAD_INDEX}},
		'{oal_pkg::OP_INSERT, 7'd0, 32'h7fff_ffff, 1'b1, '{32'd0, 1'b0, 8'd1, oal_pkg::ST_OK}},
		'{oal_pkg::OP_INSERT, 7'd1, 32'h8000_0000, 1'b1, '{32'd0, 1'b0, 8'd2, oal_pkg::ST_OK}},
		'{oal_pkg::OP_INSERT, 7'd0, 32'hffff_ffff, 1'b1, '{32'd0, 1'b0, 8'd3, oal_pkg::ST_OK}},
		'{oal_pkg::OP_GET, 7'd0, 32'd0, 1'b0, '0},
		'{oal_pkg::OP_GET, 7'd2, 32'd0, 1'b0, '0},
		'{oal_pkg::OP_GET, 7'd3, 32'd0, 1'b1, '{32'd0, 1'b0, 8'd3, oal_pkg::ST_BAD_INDEX}},
		'{oal_pkg::OP_GET, 7'd127, 32'd0, 1'b1, '{32'd0, 1'b0, 8'd3, oal_pkg::ST_BAD_INDEX}},
		'{oal_pkg::OP_SET, 7'd1, 32'd0, 1'b0, '0},
		'{oal_pkg::OP_SEARCH, 7'd0, 32'd0, 1'b0, '0},
		'{oal_pkg::OP_SEARCH, 7'd9, 32'h8000_0000, 1'b0, '0},
		'{oal_pkg::OP_SEARCH, 7'd0, 32'd12345, 1'b0, '0},
		'{oal_pkg::OP_INSERT, 7'd127, 32'd1, 1'b1, '{32'd0, 1'b0, 8'd3, oal_pkg::ST_BAD_INDEX}},
		'{oal_pkg::OP_DELETE, 7'd127, 32'd0, 1'b1, '{32'd0, 1'b0, 8'd3, oal_pkg::ST_BAD_INDEX}},
		'{oal_pkg::OP_DELETE, 7'd3, 32'd0, 1'b1, '{32'd0, 1'b0, 8'd3, oal_pkg::ST_BAD_INDEX}},
		'{oal_pkg::OP_DELETE, 7'd1, 32'd0, 1'b0, '0},
		'{OP_SPARE_HI, 7'd127, 32'hffff_ffff, 1'b1, '{32'd0, 1'b0, 8'd2, oal_pkg::ST_OK}},
		'{OP_SPARE_LO, 7'd0, 32'd7, 1'b0, '0},
		'{oal_pkg::OP_SET, 7'd1, 32'h5555_5555, 1'b0, '0},
		'{oal_pkg::OP_INSERT, 7'd2, 32'haaaa_aaaa, 1'b0, '0}
	};

	ordered_array_list_unit DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #2 clk = ~clk;

	// Apply one operation to the predicted list and return its result
	function automatic list_result_t apply_to_list(input logic [oal_pkg::OP_BITS-1:0] op,
			input logic [oal_pkg::POS_BITS-1:0] pos,
			input logic [oal_pkg::VALUE_BITS-1:0] value);
		list_result_t res;
		int p;
		int k;
		res = '{oal_pkg::READ_BITS'(0), 1'b0, oal_pkg::COUNT_OUT_BITS'(0), oal_pkg::ST_OK};
		p = int'(pos);
		case (op)
			oal_pkg::OP_GET: begin
				if (p < list_len)
					res.read_value = list_words[p];
				else
					res.status = oal_pkg::ST_BAD_INDEX;
			end
			oal_pkg::OP_SET: begin
				if (p < list_len)
					list_words[p] = value;
				else
					res.status = oal_pkg::ST_BAD_INDEX;
			end
			oal_pkg::OP_INSERT: begin
				if (list_len >= oal_pkg::CAPACITY) begin
					res.status = oal_pkg::ST_FULL;
				end else if (p > list_len) begin
					res.status = oal_pkg::ST_BAD_INDEX;
				end else begin
					for (k = list_len; k > p; k--)
						list_words[k] = list_words[k-1];
					list_words[p] = value;
					list_len++;
				end
			end
			oal_pkg::OP_DELETE: begin
				if (list_len == 0) begin
					res.status = oal_pkg::ST_EMPTY;
				end else if (p >= list_len) begin
					res.status = oal_pkg::ST_BAD_INDEX;
				end else begin
					for (k = p; k + 1 < list_len; k++)
						list_words[k] = list_words[k+1];
					list_len--;
				end
			end
			oal_pkg::OP_SEARCH: begin
				for (k = 0; k < list_len; k++)
					if (list_words[k] == value)
						res.found = 1'b1;
			end
			default: ;
		endcase
		res.count_now = oal_pkg::COUNT_OUT_BITS'(list_len);
		return res;
	endfunction

	task automatic note_mismatch(input string field, input logic [31:0] got,
			input logic [31:0] want);
		mismatches++;
		$display("%0t: %s got %0h want %0h", $time, field, got, want);
	endtask

	// Offer one item, wait for its transfer, then record the expected result
	task automatic send_item(input logic [oal_pkg::OP_BITS-1:0] op,
			input logic [oal_pkg::POS_BITS-1:0] pos,
			input logic [oal_pkg::VALUE_BITS-1:0] value, input logic typed,
			input list_result_t want);
		list_result_t predicted;
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(1, 6);
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
				: $urandom_range(1, 8);
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata <= {6'd0, value, pos, op};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		predicted = apply_to_list(op, pos, value);
		pending_results.push_back(typed ? want : predicted);
		@(negedge clk);
	endtask

	// Pick an item that mostly keeps the list growing or shrinking
	task automatic pick_item(output logic [oal_pkg::OP_BITS-1:0] op,
			output logic [oal_pkg::POS_BITS-1:0] pos,
			output logic [oal_pkg::VALUE_BITS-1:0] value);
		int r;
		int pick;
		if (fill_mode && list_len == oal_pkg::CAPACITY && $urandom_range(0, 3) == 0)
			fill_mode = 1'b0;
		else if (!fill_mode && list_len == 0 && $urandom_range(0, 3) == 0)
			fill_mode = 1'b1;

		r = $urandom_range(0, 99);
		if (r < 70)
			op = fill_mode ? oal_pkg::OP_INSERT : oal_pkg::OP_DELETE;
		else if (r < 78)
			op = fill_mode ? oal_pkg::OP_DELETE : oal_pkg::OP_INSERT;
		else if (r < 86)
			op = oal_pkg::OP_GET;
		else if (r < 92)
			op = oal_pkg::OP_SET;
		else if (r < 98)
			op = oal_pkg::OP_SEARCH;
		else
			op = oal_pkg::OP_BITS'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));

		// Position: mostly in range, sometimes an edge, sometimes anything
		r = $urandom_range(0, 99);
		if (r < 10)
			pos = oal_pkg::POS_BITS'($urandom_range(0, 127));
		else if (r < 20)
			pos = (op == oal_pkg::OP_INSERT || list_len == 0) ?
				oal_pkg::POS_BITS'(list_len) : oal_pkg::POS_BITS'(0);
		else if (op == oal_pkg::OP_INSERT)
			pos = oal_pkg::POS_BITS'($urandom_range(0, list_len));
		else
			pos = (list_len > 0) ? oal_pkg::POS_BITS'($urandom_range(0, list_len - 1)) : '0;

		// Value: list element, wide random, extremes, or narrow range for duplicates
		r = $urandom_range(0, 99);
		if (op == oal_pkg::OP_SEARCH && list_len > 0 && r < 50) begin
			pick = $urandom_range(0, list_len - 1);
			value = list_words[pick];
		end else if (r < 65) begin
			value = $urandom;
		end else if (r < 80) begin
			case ($urandom_range(0, 4))
				0: value = 32'h0000_0000;
				1: value = 32'hffff_ffff;
				2: value = 32'h8000_0000;
				3: value = 32'h7fff_ffff;
				default: value = 32'h0000_0001;
			endcase
		end else begin
			value = $urandom_range(0, 15);
		end
	endtask

	// Receiver: shifting ready pattern plus one long hold-off to back up the unit
	always @(negedge clk) begin
		rx_phase++;
		if (rx_phase % 50 == 0)
			rx_mode = rx_mode_t'($urandom_range(0, 2));
		if (hold_cycles > 0) begin
			hold_cycles--;
			m_tready <= 1'b0;
		end else if (!held_off && results_seen >= 40) begin
			held_off = 1'b1;
			hold_cycles = HOLD_OFF_CYCLES;
			m_tready <= 1'b0;
		end else begin
			case (rx_mode)
				RX_OPEN:   m_tready <= 1'b1;
				RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
				default:   m_tready <= (rx_phase % 4 == 0);
			endcase
		end
	end

	// Compare each result transfer with the oldest expectation
	always @(posedge clk) begin
		list_result_t got;
		list_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			got.read_value = m_tdata[31:0];
			got.found = m_tdata[32];
			got.count_now = m_tdata[40:33];
			got.status = oal_pkg::status_t'(m_tdata[42:41]);
			if (pending_results.size() == 0) begin
				note_mismatch("unexpected result", m_tdata[31:0], 32'd0);
			end else begin
				want = pending_results.pop_front();
				if (got.read_value !== want.read_value)
					note_mismatch("read_value", got.read_value, want.read_value);
				if (got.found !== want.found)
					note_mismatch("found", 32'(got.found), 32'(want.found));
				if (got.count_now !== want.count_now)
					note_mismatch("count_now", 32'(got.count_now), 32'(want.count_now));
				if (got.status !== want.status)
					note_mismatch("status", 32'(got.status), 32'(want.status));
			end
		end
	end

	initial begin
		#4_000_000;
		$display("end of test: mismatches");
		$finish;
	end

	initial begin
		logic [oal_pkg::OP_BITS-1:0] op;
		logic [oal_pkg::POS_BITS-1:0] pos;
		logic [oal_pkg::VALUE_BITS-1:0] value;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (opening_rows[i])
			send_item(opening_rows[i].op, opening_rows[i].pos, opening_rows[i].value,
				opening_rows[i].typed, opening_rows[i].want);

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			pick_item(op, pos, value);
			send_item(op, pos, value, 1'b0, '0);
		end
		s_tvalid <= 1'b0;

		// Let the last results drain, then watch for stray transfers
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
